// File: sv/ptpd_pkg.sv
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared widths, constants, payload types and helpers for the point
// transform with perspective divide.
// ----------------------------------------------------------------------------
package ptpd_pkg;

    // Fixed formats: coordinates Q16.16, coefficients Q8.16
    localparam int CW        = 32;
    localparam int KW        = 24;
    localparam int FB        = 16;
    localparam int PW        = CW + KW;
    localparam int AW        = CW + KW + 2;
    localparam int NW        = AW + FB;
    localparam int NPAIR     = 8;
    localparam int NCOEF     = 2 * NPAIR;
    localparam int PAIR_W    = 2 * KW;
    localparam int CFG_IDX_W = 4;
    localparam int NLANE     = 3;

    // Clamp limits of the coordinate format
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // Reset contents of the coefficient registers: identity matrix
    localparam logic [PAIR_W-1:0] PAIR_ZERO  = {PAIR_W{1'b0}};
    localparam logic [PAIR_W-1:0] PAIR_ONE_LO =
        {{(PAIR_W-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic [PAIR_W-1:0] PAIR_ONE_HI = PAIR_ONE_LO << KW;
    localparam logic [NPAIR-1:0][PAIR_W-1:0] COEF_RESET = {
        PAIR_ONE_HI, PAIR_ZERO, PAIR_ONE_LO, PAIR_ZERO,
        PAIR_ZERO, PAIR_ONE_HI, PAIR_ZERO, PAIR_ONE_LO
    };

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic                 divide;
    } t_point_in;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 w_is_zero;
        logic                 saturated;
    } t_point_out;

    typedef logic [NCOEF-1:0][KW-1:0] t_coef_mat;
    typedef logic [3:0][AW-1:0]       t_acc_vec;

    // Decisions taken before the divider, carried alongside it
    typedef struct packed {
        logic             use_div;
        logic             w_zero_flag;
        logic             undiv_sat;
        logic [NLANE-1:0] q_neg;
        logic [NLANE-1:0] ovf;
    } t_div_ctl;

    typedef struct packed {
        t_div_ctl                   ctl;
        logic [AW-1:0]              den;
        logic [NLANE-1:0][CW-1:0]   undiv;
        logic [NLANE-1:0][NW-1:0]   rem;
        logic [NLANE-1:0][CW-1:0]   quo;
    } t_div_pkt;

    // Full signed product of a coordinate and a coefficient
    function automatic logic [PW-1:0] mul_s(logic signed [CW-1:0] a,
                                            logic signed [KW-1:0] b);
        logic signed [PW-1:0] p;
        p = a * b;
        return p;
    endfunction

endpackage

// File: sv/point_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// point_transform_perspective_divide
// Homogeneous 4x4 point transform with optional perspective divide.
// ----------------------------------------------------------------------------
// One point enters per cycle while o_in_stall is low, and each accepted
// transaction passes through two multiply-accumulate stages, one preparation
// stage, a 32-stage restoring divider that settles one quotient bit per stage
// for x, y and z together, and the output register. Behind the output
// register sits a one-entry skid buffer, so a transaction is still accepted
// while a finished result waits; input stall is raised only once that buffer
// holds a result. Coefficients reset to the identity matrix and must be
// written only while no transaction is in flight.
module point_transform_perspective_divide
    import ptpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_point_in            i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_point_out           o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAIR_W-1:0]    i_cfg_data
);

    logic [NPAIR-1:0][PAIR_W-1:0] r_coef_pair;
    t_coef_mat                    coef_mat;
    logic                         adv;
    logic                         mac_v;
    t_acc_vec                     mac_acc;
    logic                         mac_div;
    logic                         stg_v   [CW+1];
    t_div_pkt                     stg_pkt [CW+1];
    t_div_pkt                     fin;
    t_point_out                   tail;
    logic                         tail_v;
    logic [NLANE-1:0][CW-1:0]     qval;
    logic [NLANE-1:0]             qsat;
    logic                         out_take;
    logic                         r_out_v;
    t_point_out                   r_out;
    logic                         r_skid_v;
    t_point_out                   r_skid;

    // Coefficient registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_pair <= COEF_RESET;
        end else if (i_cfg_valid && o_cfg_ready
                     && (i_cfg_index < CFG_IDX_W'(NPAIR))) begin
            r_coef_pair[i_cfg_index[$clog2(NPAIR)-1:0]] <= i_cfg_data;
        end
    end

    // Unpack matrix entries, row-major
    always_comb begin
        for (int k = 0; k < NPAIR; k++) begin
            coef_mat[2*k]   = r_coef_pair[k][KW-1:0];
            coef_mat[2*k+1] = r_coef_pair[k][PAIR_W-1:KW];
        end
    end

    // Hold the whole pipeline while the skid buffer is occupied
    assign adv        = !r_skid_v;
    assign o_in_stall = r_skid_v;

    ptpd_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (i_in_valid),
        .i_point  (i_in_data),
        .i_coef   (coef_mat),
        .o_valid  (mac_v),
        .o_acc    (mac_acc),
        .o_divide (mac_div)
    );

    ptpd_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (mac_v),
        .i_acc    (mac_acc),
        .i_divide (mac_div),
        .o_valid  (stg_v[0]),
        .o_pkt    (stg_pkt[0])
    );

    // Divider: most significant quotient bit first
    for (genvar k = 0; k < CW; k++) begin : g_div
        ptpd_div_stage #(
            .BIT (CW - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (stg_v[k]),
            .i_pkt   (stg_pkt[k]),
            .o_valid (stg_v[k+1]),
            .o_pkt   (stg_pkt[k+1])
        );
    end

    // Apply quotient signs, clamp and select the path
    always_comb begin
        fin = stg_pkt[CW];
        for (int l = 0; l < NLANE; l++) begin
            if (fin.ctl.q_neg[l]) begin
                qsat[l] = fin.ctl.ovf[l] || (fin.quo[l] > COORD_MIN);
                qval[l] = qsat[l] ? COORD_MIN : (~fin.quo[l] + CW'(1));
            end else begin
                qsat[l] = fin.ctl.ovf[l] || fin.quo[l][CW-1];
                qval[l] = qsat[l] ? COORD_MAX : fin.quo[l];
            end
        end
        if (fin.ctl.use_div) begin
            tail.out_x     = qval[0];
            tail.out_y     = qval[1];
            tail.out_z     = qval[2];
            tail.saturated = |qsat;
        end else begin
            tail.out_x     = fin.undiv[0];
            tail.out_y     = fin.undiv[1];
            tail.out_z     = fin.undiv[2];
            tail.saturated = fin.ctl.undiv_sat;
        end
        tail.w_is_zero = fin.ctl.w_zero_flag;
        tail_v         = stg_v[CW];
    end

    // Output register with skid buffer
    assign out_take = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= tail_v;
            end
        end else if (tail_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= r_skid_v ? r_skid : tail;
        end else if (adv && tail_v) begin
            r_skid <= tail;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // Skid buffer only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid buffer occupied with empty output register");

    // A finished result arriving at a held output is caught in the skid buffer
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall && !r_skid_v && tail_v) |=> r_skid_v)
        else $error("result dropped at held output");

    // Output drains when taken and nothing follows
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_stall && !r_skid_v && !tail_v) |=> !r_out_v)
        else $error("result repeated after transaction");

    // Skid buffer empties whenever the output is taken
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_out_stall) |=> (!r_skid_v && r_out_v))
        else $error("skid buffer not drained");
`endif

endmodule

// File: sv/ptpd_mac.sv
// ----------------------------------------------------------------------------
// ptpd_mac
// Two stages: twelve coordinate-by-coefficient products, then the four
// column sums including the translation row.
// ----------------------------------------------------------------------------
module ptpd_mac
    import ptpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_point_in i_point,
    input  t_coef_mat i_coef,
    output logic      o_valid,
    output t_acc_vec  o_acc,
    output logic      o_divide
);

    logic [NLANE-1:0][CW-1:0]       pt;
    logic [NLANE-1:0][3:0][PW-1:0]  n_prod;
    logic [NLANE-1:0][3:0][PW-1:0]  r_prod;
    logic [3:0][AW-1:0]             n_bias;
    logic [3:0][AW-1:0]             r_bias;
    logic                           r_div1;
    logic                           r_v1;
    t_acc_vec                       n_acc;
    t_acc_vec                       r_acc;
    logic                           r_div2;
    logic                           r_v2;

    // Form the products and the scaled translation terms
    always_comb begin
        pt[0] = i_point.point_x;
        pt[1] = i_point.point_y;
        pt[2] = i_point.point_z;
        for (int r = 0; r < NLANE; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_prod[r][c] = mul_s(pt[r], i_coef[4*r+c]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            n_bias[c] = {{(AW-KW-FB){i_coef[12+c][KW-1]}}, i_coef[12+c], {FB{1'b0}}};
        end
    end

    // Sum each column exactly
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_acc[c] = r_bias[c]
                     + {{(AW-PW){r_prod[0][c][PW-1]}}, r_prod[0][c]}
                     + {{(AW-PW){r_prod[1][c][PW-1]}}, r_prod[1][c]}
                     + {{(AW-PW){r_prod[2][c][PW-1]}}, r_prod[2][c]};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_bias <= n_bias;
            r_div1 <= i_point.divide;
            r_acc  <= n_acc;
            r_div2 <= r_div1;
        end
    end

    assign o_valid  = r_v2;
    assign o_acc    = r_acc;
    assign o_divide = r_div2;

endmodule

// File: sv/ptpd_prep.sv
// ----------------------------------------------------------------------------
// ptpd_prep
// Takes magnitudes and signs, checks w, forms the undivided results and
// flags quotients that cannot fit before the divider starts.
// ----------------------------------------------------------------------------
module ptpd_prep
    import ptpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_acc_vec i_acc,
    input  logic     i_divide,
    output logic     o_valid,
    output t_div_pkt o_pkt
);

    t_div_pkt         n_pkt;
    t_div_pkt         r_pkt;
    logic             r_v;
    logic [AW-1:0]    w;
    logic             w_zero;
    logic             w_neg;
    logic [NW-1:0]    den_ext;
    logic [AW-1:0]    a;
    logic [AW-1:0]    mag;
    logic [NLANE-1:0] lane_sat;
    logic             fits;

    always_comb begin
        w       = i_acc[3];
        w_zero  = (w == '0);
        w_neg   = w[AW-1];
        n_pkt   = '0;
        a       = '0;
        mag     = '0;
        fits    = 1'b0;
        n_pkt.den = w_neg ? (~w + AW'(1)) : w;
        den_ext = {{FB{1'b0}}, n_pkt.den};
        for (int l = 0; l < NLANE; l++) begin
            a   = i_acc[l];
            mag = a[AW-1] ? (~a + AW'(1)) : a;
            n_pkt.rem[l]       = {mag, {FB{1'b0}}};
            n_pkt.ctl.ovf[l]   = (n_pkt.rem[l] >> CW) >= den_ext;
            n_pkt.ctl.q_neg[l] = a[AW-1] ^ w_neg;
            // Undivided: drop fraction bits, clamp if the top does not fit
            fits = (&a[AW-1:FB+CW-1]) | ~(|a[AW-1:FB+CW-1]);
            lane_sat[l] = !fits;
            if (fits) begin
                n_pkt.undiv[l] = a[FB+CW-1:FB];
            end else begin
                n_pkt.undiv[l] = a[AW-1] ? COORD_MIN : COORD_MAX;
            end
        end
        n_pkt.ctl.use_div     = i_divide && !w_zero;
        n_pkt.ctl.w_zero_flag = i_divide && w_zero;
        n_pkt.ctl.undiv_sat   = |lane_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pkt <= n_pkt;
        end
    end

    assign o_valid = r_v;
    assign o_pkt   = r_pkt;

endmodule

// File: sv/ptpd_div_stage.sv
// ----------------------------------------------------------------------------
// ptpd_div_stage
// One restoring-division step for all three lanes: settles quotient bit BIT.
// ----------------------------------------------------------------------------
module ptpd_div_stage
    import ptpd_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_pkt i_pkt,
    output logic     o_valid,
    output t_div_pkt o_pkt
);

    t_div_pkt      n_pkt;
    t_div_pkt      r_pkt;
    logic          r_v;
    logic [NW-1:0] den_ext;

    // Subtract the shifted divisor where it fits
    always_comb begin
        n_pkt   = i_pkt;
        den_ext = {{FB{1'b0}}, i_pkt.den};
        for (int l = 0; l < NLANE; l++) begin
            if ((i_pkt.rem[l] >> BIT) >= den_ext) begin
                n_pkt.rem[l]      = i_pkt.rem[l] - (den_ext << BIT);
                n_pkt.quo[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pkt <= n_pkt;
        end
    end

    assign o_valid = r_v;
    assign o_pkt   = r_pkt;

endmodule
